// ===== hdl/isbm_pkg.sv =====
package isbm_pkg;

  // Store geometry
  localparam int NODE_COUNT     = 1024;
  localparam int NODE_BITS      = $clog2(NODE_COUNT);
  localparam int MEASURE_BITS   = 32;
  localparam int FIELD_MEAS_BITS = 32;
  localparam int THRESHOLD_BITS = 32;
  localparam int CMP_BITS       = (MEASURE_BITS > THRESHOLD_BITS) ? MEASURE_BITS
                                                                  : THRESHOLD_BITS;

  // Register port
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam int REG_IDX_BITS   = APB_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = '0;

  typedef logic [NODE_BITS-1:0]      node_t;
  typedef logic [MEASURE_BITS-1:0]   measure_t;
  typedef logic [THRESHOLD_BITS-1:0] threshold_t;
  typedef logic [CMP_BITS-1:0]       cmp_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SELECT = 2'd1,
    OP_EDGE   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ_A,
    S_CMP_A,
    S_CMP_B,
    S_CMP_AB,
    S_CMP_BA,
    S_RESULT
  } state_t;

  // Access request to the node store
  typedef struct packed {
    logic     meas_we;
    logic     mark_we;
    node_t    wr_addr;
    measure_t wr_meas;
    logic     wr_mark;
    node_t    rd_addr;
  } store_req_t;

endpackage

// ===== hdl/isbm_in_if.sv =====
interface isbm_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        operation;
  logic [isbm_pkg::NODE_BITS-1:0]    node;
  logic [isbm_pkg::NODE_BITS-1:0]    neighbor;
  logic                              edge_present;
  logic [isbm_pkg::FIELD_MEAS_BITS-1:0] measure;
  logic                              marker_in;

  modport source (output valid, operation, node, neighbor, edge_present, measure,
                  marker_in, input ready);
  modport sink   (input valid, operation, node, neighbor, edge_present, measure,
                  marker_in, output ready);
endinterface

// ===== hdl/isbm_out_if.sv =====
interface isbm_out_if;
  logic valid;
  logic ready;
  logic marker_out;
  logic node_active;

  modport source (output valid, marker_out, node_active, input ready);
  modport sink   (input valid, marker_out, node_active, output ready);
endinterface

// ===== hdl/isbm_store.sv =====
module isbm_store (
  input  logic                 clk,
  input  isbm_pkg::store_req_t req,
  output isbm_pkg::measure_t   rd_meas,
  output logic                 rd_mark
);
  import isbm_pkg::*;

  measure_t meas_mem [NODE_COUNT];
  logic     mark_mem [NODE_COUNT];

  // Measure memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.meas_we) begin
      meas_mem[req.wr_addr] <= req.wr_meas;
    end
    rd_meas <= meas_mem[req.rd_addr];
  end

  // Marker memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.mark_we) begin
      mark_mem[req.wr_addr] <= req.wr_mark;
    end
    rd_mark <= mark_mem[req.rd_addr];
  end

endmodule

// ===== hdl/independent_set_by_measure.sv =====
// Result: read, select and write end after a single compare; edge compare uses
// one shared comparator up to four times.
// The next item is taken only once the sequencer has handed its result to the
// output register.
// Reset: synchronous; marker store is swept to zero after reset, no items
// accepted meanwhile. Threshold resets to zero.
module independent_set_by_measure (
  input  logic                                clk,
  input  logic                                rst,
  isbm_in_if.sink                             item,
  isbm_out_if.source                          result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [isbm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [isbm_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [isbm_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import isbm_pkg::*;

  state_t     state, state_next;
  node_t      clr_cnt;
  threshold_t thr;

  op_t        op_q;
  node_t      node_q, nb_q;
  logic       edge_q, mark_in_q;
  measure_t   meas_in_q;
  measure_t   meas_a, meas_b;
  logic       mark_a, active_a;

  logic       out_valid, out_mark, out_active;

  store_req_t req;
  measure_t   rd_meas;
  logic       rd_mark;

  cmp_t       cmp_x, cmp_y;
  logic       cmp_gt;
  logic       in_ready, in_fire, out_load;
  logic       reg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;

  isbm_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_meas (rd_meas),
    .rd_mark (rd_mark)
  );

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign reg_wr  = psel && penable && pwrite && (reg_idx == REG_THRESHOLD);
  assign prdata  = (reg_idx == REG_THRESHOLD) ? APB_DATA_BITS'(thr) : '0;

  // Shared comparator
  assign cmp_gt = cmp_x > cmp_y;

  assign in_fire      = item.valid && in_ready;
  assign item.ready   = in_ready;
  assign result.valid       = out_valid;
  assign result.marker_out  = out_mark;
  assign result.node_active = out_active;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == node_t'(NODE_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = (op_t'(item.operation) == OP_WRITE) ? S_WRITE : S_READ_A;
        end
      end
      S_WRITE:  state_next = S_READ_A;
      S_READ_A: state_next = S_CMP_A;
      S_CMP_A: begin
        state_next = (op_q == OP_EDGE && edge_q && cmp_gt) ? S_CMP_B : S_RESULT;
      end
      S_CMP_B:  state_next = cmp_gt ? S_CMP_AB : S_RESULT;
      S_CMP_AB: state_next = cmp_gt ? S_RESULT : S_CMP_BA;
      S_CMP_BA: state_next = S_RESULT;
      S_RESULT: begin
        if (!out_valid || result.ready) state_next = S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  // Sequencer outputs: store access, comparator operands, handshakes
  always_comb begin
    req          = '0;
    req.rd_addr  = nb_q;
    cmp_x        = CMP_BITS'(rd_meas);
    cmp_y        = CMP_BITS'(thr);
    in_ready     = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_CLEAR: begin
        req.mark_we = 1'b1;
        req.wr_addr = clr_cnt;
        req.wr_mark = 1'b0;
      end
      S_IDLE: in_ready = 1'b1;
      S_WRITE: begin
        req.meas_we = 1'b1;
        req.mark_we = 1'b1;
        req.wr_addr = node_q;
        req.wr_meas = meas_in_q;
        req.wr_mark = mark_in_q;
      end
      S_READ_A: req.rd_addr = node_q;
      S_CMP_A: begin
        // select puts an active node into the set
        if (op_q == OP_SELECT && cmp_gt) begin
          req.mark_we = 1'b1;
          req.wr_addr = node_q;
          req.wr_mark = 1'b1;
        end
      end
      S_CMP_B: ;
      S_CMP_AB: begin
        cmp_x = CMP_BITS'(meas_a);
        cmp_y = CMP_BITS'(meas_b);
        if (cmp_gt) begin
          req.mark_we = 1'b1;
          req.wr_addr = nb_q;
          req.wr_mark = 1'b0;
        end
      end
      S_CMP_BA: begin
        cmp_x = CMP_BITS'(meas_b);
        cmp_y = CMP_BITS'(meas_a);
        if (cmp_gt) begin
          req.mark_we = 1'b1;
          req.wr_addr = node_q;
          req.wr_mark = 1'b0;
        end
      end
      S_RESULT: out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      thr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + node_t'(1);
      if (reg_wr) thr <= THRESHOLD_BITS'(pwdata);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      op_q      <= op_t'(item.operation);
      node_q    <= item.node;
      nb_q      <= item.neighbor;
      edge_q    <= item.edge_present;
      meas_in_q <= MEASURE_BITS'(item.measure);
      mark_in_q <= item.marker_in;
    end
    if (state == S_CMP_A) begin
      meas_a   <= rd_meas;
      active_a <= cmp_gt;
      mark_a   <= (op_q == OP_SELECT && cmp_gt) ? 1'b1 : rd_mark;
    end
    if (state == S_CMP_B) meas_b <= rd_meas;
    if (state == S_CMP_BA && cmp_gt) mark_a <= 1'b0;
    if (out_load) begin
      out_mark   <= mark_a;
      out_active <= active_a;
    end
  end

endmodule
